// ----- design/hcw_pkg.sv -----
// types and constants shared by the heap chain walker
`timescale 1ns / 1ps

package hcw_pkg;

    typedef enum logic [1:0]
    {
        PH_IDLE   = 2'd0,
        PH_BEGIN1 = 2'd1,
        PH_BEGIN2 = 2'd2,
        PH_NODES  = 2'd3
    } walk_phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_BEGIN = 2'd1;
    localparam logic [1:0] ST_BAD_NODE  = 2'd2;

    localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_FILL_ENABLE = 2'd2;
    localparam logic [1:0] CFG_FILL_BYTE   = 2'd3;

    localparam logic [15:0] BEGIN_WORD1 = 16'd1;
    localparam logic [15:0] BEGIN_WORD2 = 16'd2;
    localparam logic [15:0] END_MARK    = 16'hFFFE;
    localparam logic [16:0] SUM_MAX     = 17'h1FFFF;

    typedef struct packed
    {
        logic [15:0] next_address;
        logic        read_request;
        logic        walk_done;
        logic [1:0]  status;
        logic [16:0] heap_total;
        logic [16:0] heap_free;
        logic [15:0] largest_free;
        logic        fill_valid;
        logic [15:0] fill_address;
        logic [15:0] fill_length;
        logic [7:0]  fill_value;
    } hcw_result_t;

endpackage

// ----- design/heap_chain_walker.sv -----
// heap chain walker top level: header decode, running totals and output skid buffer
`timescale 1ns / 1ps

// heap_chain_walker
// input stream (s_*): s_tuser is the command (0 start a walk, 1 deliver a word),
// s_tdata the memory word read at the address asked for by the previous result.
// every input transaction yields exactly one result transaction on m_*, carrying
// the next read address, done/status, the running total, free and largest-free
// sizes and an optional fill request for the free block just met.
// configuration: cfg_we writes cfg_wdata into register cfg_index (0 heap base,
// 1 heap limit, 2 fill enable, 3 fill byte); write only while the block is idle.
// output: the result is registered, in the skid register if a held result waits.
// throughput: one item per cycle while s_tready is high; the header decode, the
// saturating adds and the bound compare sit between the input port and result register.
// stall: a two-entry output buffer (result register plus skid register) lets
// one item be taken while a result waits; s_tready drops while the skid is full.
// reset: rst_n clears the walk state, totals, registers and output valids.
module heap_chain_walker #(
    parameter int ADDR_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // read_word[15:0]
    input  logic [0:0]   s_tuser,   // cmd[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_address[15:0], status[17:16], heap_total[34:18], heap_free[51:35],
    // largest_free[67:52], fill_address[83:68], fill_length[99:84],
    // fill_value[107:100], zero pad[111:108]
    output logic [111:0] m_tdata,
    // read_request[0], walk_done[1], fill_valid[2]
    output logic [2:0]   m_tuser
);

    logic [15:0]          heap_base_reg;
    logic [15:0]          heap_limit_reg;
    logic                 fill_enable_reg;
    logic [7:0]           fill_byte_reg;

    hcw_pkg::walk_phase_t phase_reg, phase_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [16:0]          total_reg, total_next;
    logic [16:0]          free_reg, free_next;
    logic [15:0]          largest_reg, largest_next;

    hcw_pkg::hcw_result_t res_next, out_reg, skid_reg;
    logic                 out_valid_reg, skid_valid_reg;

    logic                 accept;
    logic [15:0]          word;
    logic [15:0]          size;
    logic [16:0]          size2;
    logic [ADDR_BITS-1:0] payload;
    logic [17:0]          total_sum, free_sum;
    logic [15:0]          room;
    logic                 overrun;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign word     = s_tdata;
    assign size     = {word[15:1], 1'b0};
    assign size2    = {1'b0, size} + 17'd2;
    assign payload  = addr_reg + ADDR_BITS'(2);
    assign total_sum = {1'b0, total_reg} + {1'b0, size2};
    assign free_sum  = {1'b0, free_reg} + {1'b0, size2};
    assign room      = heap_limit_reg - size;
    assign overrun   = (heap_limit_reg < size) || (ADDR_BITS'(room) < payload);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= '0;
            heap_limit_reg  <= '0;
            fill_enable_reg <= 1'b0;
            fill_byte_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcw_pkg::CFG_HEAP_BASE:   heap_base_reg   <= cfg_wdata;
                hcw_pkg::CFG_HEAP_LIMIT:  heap_limit_reg  <= cfg_wdata;
                hcw_pkg::CFG_FILL_ENABLE: fill_enable_reg <= cfg_wdata[0];
                hcw_pkg::CFG_FILL_BYTE:   fill_byte_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        total_next   = total_reg;
        free_next    = free_reg;
        largest_next = largest_reg;
        res_next     = '0;

        if (s_tuser[0] == 1'b0)
        begin
            total_next   = '0;
            free_next    = '0;
            largest_next = '0;
            if (heap_base_reg == 16'd0)
            begin
                phase_next         = hcw_pkg::PH_IDLE;
                res_next.walk_done = 1'b1;
            end
            else
            begin
                addr_next             = ADDR_BITS'(heap_base_reg);
                phase_next            = hcw_pkg::PH_BEGIN1;
                res_next.next_address = heap_base_reg;
                res_next.read_request = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                hcw_pkg::PH_BEGIN1, hcw_pkg::PH_BEGIN2:
                begin
                    if ((phase_reg == hcw_pkg::PH_BEGIN1 && word != hcw_pkg::BEGIN_WORD1) ||
                        (phase_reg == hcw_pkg::PH_BEGIN2 && word != hcw_pkg::BEGIN_WORD2))
                    begin
                        phase_next         = hcw_pkg::PH_IDLE;
                        res_next.walk_done = 1'b1;
                        res_next.status    = hcw_pkg::ST_BAD_BEGIN;
                    end
                    else
                    begin
                        // second begin word also skips the two-byte dummy payload
                        if (phase_reg == hcw_pkg::PH_BEGIN1)
                        begin
                            addr_next  = addr_reg + ADDR_BITS'(2);
                            phase_next = hcw_pkg::PH_BEGIN2;
                        end
                        else
                        begin
                            addr_next  = addr_reg + ADDR_BITS'(4);
                            phase_next = hcw_pkg::PH_NODES;
                        end
                        res_next.next_address = addr_next[15:0];
                        res_next.read_request = 1'b1;
                    end
                end
                hcw_pkg::PH_NODES:
                begin
                    if (size == hcw_pkg::END_MARK)
                    begin
                        phase_next         = hcw_pkg::PH_IDLE;
                        res_next.walk_done = 1'b1;
                    end
                    else
                    begin
                        total_next = total_sum[17] ? hcw_pkg::SUM_MAX : total_sum[16:0];
                        if (word[0])
                        begin
                            free_next = free_sum[17] ? hcw_pkg::SUM_MAX : free_sum[16:0];
                            if (size > largest_reg)
                                largest_next = size;
                            if (fill_enable_reg)
                            begin
                                res_next.fill_valid   = 1'b1;
                                res_next.fill_address = payload[15:0];
                                res_next.fill_length  = size;
                                res_next.fill_value   = fill_byte_reg;
                            end
                        end
                        if (overrun)
                        begin
                            phase_next         = hcw_pkg::PH_IDLE;
                            res_next.walk_done = 1'b1;
                            res_next.status    = hcw_pkg::ST_BAD_NODE;
                        end
                        else
                        begin
                            addr_next             = payload + ADDR_BITS'(size);
                            res_next.next_address = addr_next[15:0];
                            res_next.read_request = 1'b1;
                        end
                    end
                end
                default: ;   // word delivered while idle is dropped
            endcase
        end

        res_next.heap_total   = total_next;
        res_next.heap_free    = free_next;
        res_next.largest_free = largest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hcw_pkg::PH_IDLE;
            addr_reg    <= '0;
            total_reg   <= '0;
            free_reg    <= '0;
            largest_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            total_reg   <= total_next;
            free_reg    <= free_next;
            largest_reg <= largest_next;
        end
    end

    // output buffer: result register in front, skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_tready)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.fill_value, out_reg.fill_length,
                       out_reg.fill_address, out_reg.largest_free, out_reg.heap_free,
                       out_reg.heap_total, out_reg.status, out_reg.next_address};
    assign m_tuser  = {out_reg.fill_valid, out_reg.walk_done, out_reg.read_request};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the result register is empty");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_done_excludes_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.walk_done && out_reg.read_request))
        else $error("result both finishes the walk and asks for a read");

    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.status != hcw_pkg::ST_OK) |-> out_reg.walk_done)
        else $error("error status without walk done");

endmodule
